[design/svm_pkg.sv]
// Shared types and constants for the sample voice mixer.
// No dependencies; imported by every module of the block.
package svm_pkg;

   localparam int SMP_W   = 16;  // sample word width
   localparam int POS_W   = 17;  // sound length / play position width
   localparam int SUM_W   = 18;  // width of first address plus position
   localparam int IDX_W   = 4;   // sound index field width
   localparam int GRANT_W = 4;   // granted voice field width
   localparam int MASK_W  = 8;   // active voice mask width

   // Request opcodes
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_DEFINE = 2'd1,
      OP_PLAY   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_TICK  = 3'b100
   } state_type;

   // Side information that travels with an address through the modulo unit
   typedef struct packed {
      logic             wr;    // sample write, commit at the output
      logic             add;   // tick voice that contributes a sample
      logic             last;  // last voice of a tick
      logic [SMP_W-1:0] data;  // sample word to write
   } red_tag_type;

   // Sound descriptor
   typedef struct packed {
      logic [SMP_W-1:0] first;
      logic [POS_W-1:0] frames;
   } desc_type;

endpackage

[design/svm_modred.sv]
// Pipelined address reduction: x mod DEPTH by reciprocal multiplication.
// Depends on svm_pkg. Registered stages a, b and c; one word per cycle.
module svm_modred import svm_pkg::*; #(
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [SUM_W-1:0]         in_x,
   input  red_tag_type              in_tag,
   output logic                     out_valid,
   output logic [$clog2(DEPTH)-1:0] out_rem,
   output red_tag_type              out_tag
);

   localparam int AW = $clog2(DEPTH);
   localparam int K  = SUM_W + AW;
   localparam longint unsigned RECIP = ((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
   localparam int RW = $clog2(RECIP + 64'd1);
   localparam int QW = (SUM_W >= AW) ? (SUM_W - AW + 2) : 1;
   localparam int PW = K + QW;
   localparam int DW = $clog2(DEPTH + 1);
   localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
   localparam logic [DW-1:0] DEPTH_V = DW'(DEPTH);

   logic              a_valid_ff, b_valid_ff, c_valid_ff;
   logic [SUM_W-1:0]  a_x_ff, b_x_ff;
   red_tag_type       a_tag_ff, b_tag_ff, c_tag_ff;
   logic [PW-1:0]     prod_in, a_prod_ff;
   logic [QW-1:0]     quot;
   logic [QW+DW-1:0]  qd_in;
   logic [SUM_W-1:0]  b_qd_ff;
   logic [AW-1:0]     rem_in, c_rem_ff;

   // quotient = floor(x * RECIP / 2^K), exact for every 18-bit x
   assign prod_in = PW'(in_x) * PW'(RECIP_V);
   assign quot    = a_prod_ff[PW-1:K];
   assign qd_in   = (QW+DW)'(quot) * (QW+DW)'(DEPTH_V);
   assign rem_in  = AW'(b_x_ff - b_qd_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      a_x_ff    <= in_x;
      a_tag_ff  <= in_tag;
      a_prod_ff <= prod_in;
      b_x_ff    <= a_x_ff;
      b_tag_ff  <= a_tag_ff;
      b_qd_ff   <= SUM_W'(qd_in);
      c_tag_ff  <= b_tag_ff;
      c_rem_ff  <= rem_in;
   end

   assign out_valid = c_valid_ff;
   assign out_rem   = c_rem_ff;
   assign out_tag   = c_tag_ff;

endmodule

[design/svm_sample_ram.sv]
// Sample store: single-port-write, registered-read synchronous RAM.
// Depends on svm_pkg for the word width.
module svm_sample_ram import svm_pkg::*; #(
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [SMP_W-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [SMP_W-1:0]         rd_data
);

   logic [SMP_W-1:0] mem [DEPTH];
   logic [SMP_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sample_voice_mixer_core.sv]
// Sample playback mixer: VOICES voices playing SOUNDS descriptors out of a sample RAM.
// Define and play words are answered without entering a busy state; a sample write goes
// through the address reduction pipeline, and a tick walks the voices one per cycle through
// descriptor RAM, the address reduction pipeline and the sample RAM read port. busy is high
// while a write or tick is in progress; each result appears on rsp_* for one cycle with
// rsp_valid, and the receiver cannot stall it. Sample words must be written before a sound
// reads them. Depends on svm_pkg, svm_modred and svm_sample_ram.
module sample_voice_mixer_core import svm_pkg::*; #(
   parameter int VOICES       = 8,
   parameter int SOUNDS       = 16,
   parameter int SAMPLE_DEPTH = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_op,
   input  logic [15:0]               req_sample_addr,
   input  logic signed [15:0]        req_sample_value,
   input  logic [IDX_W-1:0]          req_sound_index,
   input  logic [15:0]               req_sound_start,
   input  logic [POS_W-1:0]          req_sound_length,
   output logic                      rsp_valid,
   output logic signed [15:0]        rsp_left,
   output logic signed [15:0]        rsp_right,
   output logic [GRANT_W-1:0]        rsp_granted_voice,
   output logic [MASK_W-1:0]         rsp_active_mask
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SW = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam logic [VW-1:0]      LAST_VOICE = VW'(VOICES - 1);
   localparam logic [GRANT_W-1:0] NO_VOICE   = GRANT_W'(VOICES);
   localparam logic [31:0]        SOUNDS_V   = 32'(SOUNDS);

   // control state
   state_type          state_ff, state_in;
   logic [VW-1:0]      vcnt_ff, vcnt_in;
   logic               issue_ff, issue_in;
   logic signed [15:0] mix_ff, mix_in;

   // voice table
   logic [VOICES-1:0]  vbusy_ff, busy_in;
   logic [SW-1:0]      voice_sound_ff [VOICES];
   logic [POS_W-1:0]   voice_pos_ff [VOICES];

   // descriptor RAM with valid bits
   desc_type           desc_mem [SOUNDS];
   logic [SOUNDS-1:0]  desc_vld_ff;
   desc_type           desc_rd_ff;
   logic               desc_rd_vld_ff;
   logic [SW-1:0]      desc_raddr;
   logic [SW-1:0]      desc_widx;

   // stage 1: voice state plus descriptor
   logic               s1_valid_ff, s1_valid_in;
   logic [VW-1:0]      s1_voice_ff;
   logic               s1_busy_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic               s1_last_ff;
   desc_type           s1_desc;
   logic               s1_stop, s1_add, s1_free;
   logic [POS_W-1:0]   s1_next;

   // reduction unit ports
   logic               red_in_valid;
   logic [SUM_W-1:0]   red_in_x;
   red_tag_type        red_in_tag;
   logic               red_out_valid;
   logic [AW-1:0]      red_out_rem;
   red_tag_type        red_out_tag;

   // sample RAM ports and stage 3
   logic               smp_wr_en, smp_rd_en;
   logic [SMP_W-1:0]   smp_rd_data;
   logic               s3_valid_ff, s3_add_ff, s3_last_ff;
   logic signed [16:0] sum_w;
   logic signed [15:0] sat_w;

   // request decode
   logic               accept;
   op_type             op;
   logic               snd_ok;
   logic               free_found;
   logic [VW-1:0]      free_idx;
   logic               play_go, define_go, write_go, tick_go;
   logic [MASK_W-1:0]  mask_w;

   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_mix_ff, rsp_mix_in;
   logic [GRANT_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign op        = op_type'(req_op);
   assign snd_ok    = {{(32-IDX_W){1'b0}}, req_sound_index} < SOUNDS_V;
   assign desc_widx = SW'(req_sound_index);
   assign play_go   = accept && (op == OP_PLAY) && snd_ok && free_found;
   assign define_go = accept && (op == OP_DEFINE) && snd_ok;
   assign write_go  = accept && (op == OP_WRITE);
   assign tick_go   = accept && (op == OP_TICK);

   // lowest free voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!vbusy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VW'(i);
         end
      end
   end

   // stage 1 evaluation: stop, advance, free
   always_comb begin
      s1_desc = desc_rd_vld_ff ? desc_rd_ff : '0;
      s1_stop = (s1_pos_ff >= s1_desc.frames);
      s1_add  = s1_busy_ff && !s1_stop;
      s1_next = s1_pos_ff + POS_W'(1);
      s1_free = s1_busy_ff && (s1_stop || (s1_next == s1_desc.frames));
   end

   // busy bits after this cycle
   always_comb begin
      busy_in = vbusy_ff;
      if (play_go) begin
         busy_in[free_idx] = 1'b1;
      end
      if (s1_valid_ff && s1_free) begin
         busy_in[s1_voice_ff] = 1'b0;
      end
   end

   // visible part of the busy bits
   for (genvar gi = 0; gi < MASK_W; gi++) begin : g_mask
      if (gi < VOICES) begin : g_on
         assign mask_w[gi] = busy_in[gi];
      end else begin : g_off
         assign mask_w[gi] = 1'b0;
      end
   end

   // reduction input: tick addresses or the write address
   always_comb begin
      red_in_valid = 1'b0;
      red_in_x     = '0;
      red_in_tag   = '0;
      if (s1_valid_ff) begin
         red_in_valid   = 1'b1;
         red_in_x       = SUM_W'(s1_desc.first) + SUM_W'(s1_pos_ff);
         red_in_tag.add = s1_add;
         red_in_tag.last = s1_last_ff;
      end else if (write_go) begin
         red_in_valid    = 1'b1;
         red_in_x        = SUM_W'(req_sample_addr);
         red_in_tag.wr   = 1'b1;
         red_in_tag.data = req_sample_value;
      end
   end

   assign smp_wr_en = red_out_valid && red_out_tag.wr;
   assign smp_rd_en = red_out_valid && !red_out_tag.wr;

   // saturating accumulate
   always_comb begin
      sum_w = {mix_ff[15], mix_ff} +
              (s3_add_ff ? {smp_rd_data[15], smp_rd_data} : 17'sd0);
      if (sum_w[16] != sum_w[15]) begin
         sat_w = sum_w[16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         sat_w = sum_w[15:0];
      end
   end

   // sequencer and response
   always_comb begin
      state_in     = state_ff;
      vcnt_in      = vcnt_ff;
      issue_in     = issue_ff;
      mix_in       = mix_ff;
      s1_valid_in  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_mix_in   = rsp_mix_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_mask_in  = rsp_mask_ff;
      desc_raddr   = voice_sound_ff[vcnt_ff];

      if (accept) begin
         case (op)
            OP_WRITE: begin
               state_in = ST_WRITE;
            end
            OP_DEFINE: begin
               rsp_valid_in = 1'b1;
               rsp_mix_in   = '0;
               rsp_grant_in = NO_VOICE;
               rsp_mask_in  = mask_w;
            end
            OP_PLAY: begin
               rsp_valid_in = 1'b1;
               rsp_mix_in   = '0;
               rsp_grant_in = play_go ? GRANT_W'(free_idx) : NO_VOICE;
               rsp_mask_in  = mask_w;
            end
            OP_TICK: begin
               state_in = ST_TICK;
               vcnt_in  = '0;
               issue_in = 1'b1;
               mix_in   = '0;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end

      // walk voices one per cycle
      if (state_ff == ST_TICK && issue_ff) begin
         s1_valid_in = 1'b1;
         vcnt_in     = vcnt_ff + VW'(1);
         if (vcnt_ff == LAST_VOICE) begin
            issue_in = 1'b0;
         end
      end

      // sample write commits at the reduction output
      if (smp_wr_en) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_mix_in   = '0;
         rsp_grant_in = NO_VOICE;
         rsp_mask_in  = mask_w;
      end

      // mix and finish the tick
      if (s3_valid_ff) begin
         mix_in = sat_w;
         if (s3_last_ff) begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_mix_in   = sat_w;
            rsp_grant_in = NO_VOICE;
            rsp_mask_in  = mask_w;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         vcnt_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vbusy_ff     <= '0;
         desc_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         vcnt_ff      <= vcnt_in;
         s1_valid_ff  <= s1_valid_in;
         s3_valid_ff  <= smp_rd_en;
         rsp_valid_ff <= rsp_valid_in;
         vbusy_ff     <= busy_in;
         if (define_go) begin
            desc_vld_ff[desc_widx] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mix_ff       <= mix_in;
      rsp_mix_ff   <= rsp_mix_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_mask_ff  <= rsp_mask_in;
      s1_voice_ff  <= vcnt_ff;
      s1_busy_ff   <= vbusy_ff[vcnt_ff];
      s1_pos_ff    <= voice_pos_ff[vcnt_ff];
      s1_last_ff   <= (vcnt_ff == LAST_VOICE);
      s3_add_ff    <= red_out_tag.add;
      s3_last_ff   <= red_out_tag.last;
   end

   // voice sound and position; a play and a tick never overlap
   always_ff @(posedge clock) begin
      if (play_go) begin
         voice_sound_ff[free_idx] <= SW'(req_sound_index);
         voice_pos_ff[free_idx]   <= '0;
      end
      if (s1_valid_ff && s1_add) begin
         voice_pos_ff[s1_voice_ff] <= s1_next;
      end
   end

   // descriptor RAM
   always_ff @(posedge clock) begin
      if (define_go) begin
         desc_mem[desc_widx] <= '{first: req_sound_start, frames: req_sound_length};
      end
      desc_rd_ff     <= desc_mem[desc_raddr];
      desc_rd_vld_ff <= desc_vld_ff[desc_raddr];
   end

   svm_modred #(
      .DEPTH (SAMPLE_DEPTH)
   ) u_modred (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_in_valid),
      .in_x      (red_in_x),
      .in_tag    (red_in_tag),
      .out_valid (red_out_valid),
      .out_rem   (red_out_rem),
      .out_tag   (red_out_tag)
   );

   svm_sample_ram #(
      .DEPTH (SAMPLE_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (red_out_rem),
      .wr_data (red_out_tag.data),
      .rd_en   (smp_rd_en),
      .rd_addr (red_out_rem),
      .rd_data (smp_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left          = rsp_mix_ff;
   assign rsp_right         = rsp_mix_ff;
   assign rsp_granted_voice = rsp_grant_ff;
   assign rsp_active_mask   = rsp_mask_ff;

endmodule

[verif/tb.sv]
// Self-checking testbench for sample_voice_mixer_core: sample writes, sound defines, plays, ticks.
// Depends on svm_pkg and the mixer RTL. The built-in mixer model plans the stimulus and
// predicts every response word.
module tb import svm_pkg::*; ();

   localparam int NUM_VOICES   = 8;
   localparam int NUM_SOUNDS   = 16;
   localparam int RANDOM_WORDS = 1750;
   localparam int CYCLE_LIMIT  = 400000;

   // One request word, with a flag that holds it back until all responses are in
   typedef struct {
      op_type             op;
      logic [15:0]        addr;
      logic signed [15:0] value;
      logic [3:0]         idx;
      logic [15:0]        first;
      logic [16:0]        frames;
      bit                 drain;
   } mix_word_type;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [3:0]         voice;
      logic [7:0]         mask;
   } mix_frame_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = '0;
   logic [15:0]        req_sample_addr = '0;
   logic signed [15:0] req_sample_value = '0;
   logic [3:0]         req_sound_index = '0;
   logic [15:0]        req_sound_start = '0;
   logic [16:0]        req_sound_length = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_left;
   logic signed [15:0] rsp_right;
   logic [3:0]         rsp_granted_voice;
   logic [7:0]         rsp_active_mask;

   sample_voice_mixer_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_sample_addr   (req_sample_addr),
      .req_sample_value  (req_sample_value),
      .req_sound_index   (req_sound_index),
      .req_sound_start   (req_sound_start),
      .req_sound_length  (req_sound_length),
      .rsp_valid         (rsp_valid),
      .rsp_left          (rsp_left),
      .rsp_right         (rsp_right),
      .rsp_granted_voice (rsp_granted_voice),
      .rsp_active_mask   (rsp_active_mask)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mixer state, two copies: [0] follows the planned words, [1] the accepted words
   logic signed [15:0] smp_mem   [2][65536];
   logic [15:0]        snd_first [2][NUM_SOUNDS];
   logic [16:0]        snd_frames[2][NUM_SOUNDS];
   bit                 voice_on  [2][NUM_VOICES];
   logic [3:0]         voice_snd [2][NUM_VOICES];
   logic [16:0]        voice_pos [2][NUM_VOICES];
   bit                 smp_written[65536];

   mix_word_type  word_q[$];
   mix_frame_type mixer_out_q[$];
   mix_word_type  cur_word;
   bit         drain_pending = 0;
   int         n_planned = 0;
   int         n_taken = 0;
   int         n_back = 0;
   int         idle_left = 0;
   int         cycle_count = 0;
   int         error_count = 0;
   int         clip_count = 0;
   int         tick_count = 0;
   int         grant_count = 0;
   int         refuse_count = 0;

   // Apply one word to state copy k and return the response word it produces
   function automatic mix_frame_type mixer_apply(input int k, input mix_word_type w);
      mix_frame_type r;
      int         sum;
      int         len;
      int         pos;
      logic [15:0] a;
      sum = 0;
      r.voice = 4'(NUM_VOICES);
      case (w.op)
         OP_WRITE: smp_mem[k][w.addr] = w.value;
         OP_DEFINE: begin
            snd_first[k][w.idx]  = w.first;
            snd_frames[k][w.idx] = w.frames;
         end
         OP_PLAY: begin
            // lowest free voice wins
            for (int v = 0; v < NUM_VOICES; v++) begin
               if (!voice_on[k][v] && r.voice == 4'(NUM_VOICES)) begin
                  voice_on[k][v]  = 1;
                  voice_snd[k][v] = w.idx;
                  voice_pos[k][v] = '0;
                  r.voice = 4'(v);
               end
            end
         end
         OP_TICK: begin
            for (int v = 0; v < NUM_VOICES; v++) begin
               if (voice_on[k][v]) begin
                  len = snd_frames[k][voice_snd[k][v]];
                  pos = voice_pos[k][v];
                  if (pos >= len) begin
                     // empty or cut-short sound: free without adding
                     voice_on[k][v] = 0;
                  end else begin
                     a = 16'(snd_first[k][voice_snd[k][v]] + pos);
                     sum = sum + smp_mem[k][a];
                     if (sum > 32767 || sum < -32768) begin
                        sum = (sum > 0) ? 32767 : -32768;
                        if (k == 1) clip_count++;
                     end
                     pos = pos + 1;
                     voice_pos[k][v] = 17'(pos);
                     if (pos == len) voice_on[k][v] = 0;
                  end
               end
            end
         end
         default: ;
      endcase
      r.left  = 16'(sum);
      r.right = 16'(sum);
      for (int v = 0; v < 8; v++) r.mask[v] = (v < NUM_VOICES) ? voice_on[k][v] : 1'b0;
      return r;
   endfunction

   // Address the next tick would read from a never-written sample word, or -1
   function automatic int unwritten_read();
      int          res;
      int          len;
      int          pos;
      logic [15:0] a;
      res = -1;
      for (int v = 0; v < NUM_VOICES; v++) begin
         if (voice_on[0][v]) begin
            len = snd_frames[0][voice_snd[0][v]];
            pos = voice_pos[0][v];
            a   = 16'(snd_first[0][voice_snd[0][v]] + pos);
            if (pos < len && !smp_written[a] && res < 0) res = a;
         end
      end
      return res;
   endfunction

   function automatic mix_word_type rand_word(input op_type op);
      mix_word_type w;
      w.op     = op;
      w.addr   = 16'($urandom);
      w.value  = 16'($urandom);
      w.idx    = 4'($urandom);
      w.first  = 16'($urandom);
      w.frames = 17'($urandom_range(0, 65536));
      w.drain  = 0;
      return w;
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sd32767;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Queue a word; before a tick, write any sample word it would read unwritten
   task automatic plan(input mix_word_type w);
      mix_word_type fix;
      int        a;
      if (w.op == OP_TICK) begin
         a = unwritten_read();
         while (a >= 0) begin
            fix = rand_word(OP_WRITE);
            fix.addr  = 16'(a);
            fix.value = rand_sample();
            plan(fix);
            a = unwritten_read();
         end
      end
      w.drain = drain_pending;
      drain_pending = 0;
      if (w.op == OP_WRITE) smp_written[w.addr] = 1;
      void'(mixer_apply(0, w));
      word_q.push_back(w);
      n_planned++;
   endtask

   task automatic plan_write(input int a, input int val);
      mix_word_type w;
      w = rand_word(OP_WRITE);
      w.addr  = 16'(a);
      w.value = 16'(val);
      plan(w);
   endtask

   task automatic plan_define(input int idx, input int first, input int frames);
      mix_word_type w;
      w = rand_word(OP_DEFINE);
      w.idx    = 4'(idx);
      w.first  = 16'(first);
      w.frames = 17'(frames);
      plan(w);
   endtask

   task automatic plan_play(input int idx);
      mix_word_type w;
      w = rand_word(OP_PLAY);
      w.idx = 4'(idx);
      plan(w);
   endtask

   // Driver: one word per start/busy handshake, with random idle bursts
   always @(posedge clock) begin : drive_words
      mix_word_type  w;
      mix_frame_type r;
      bit         took;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            r = mixer_apply(1, cur_word);
            mixer_out_q.push_back(r);
            n_taken <= n_taken + 1;
            if (cur_word.op == OP_TICK) tick_count++;
            if (cur_word.op == OP_PLAY) begin
               if (r.voice == 4'(NUM_VOICES)) refuse_count++;
               else grant_count++;
            end
         end
         if (!start || took) begin
            if (idle_left > 0) begin
               start <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (word_q.size() == 0) begin
               start <= 1'b0;
            end else if (word_q[0].drain && (took || n_taken != n_back)) begin
               // hold off until every response is in
               start <= 1'b0;
            end else begin
               w = word_q.pop_front();
               cur_word         <= w;
               start            <= 1'b1;
               req_op           <= w.op;
               req_sample_addr  <= w.addr;
               req_sample_value <= w.value;
               req_sound_index  <= w.idx;
               req_sound_start  <= w.first;
               req_sound_length <= w.frames;
               if (word_q.size() > 150 && $urandom_range(0, 7) == 0)
                  idle_left <= $urandom_range(1, 12);
            end
         end
      end
   end

   // Monitor: each response word against the oldest prediction
   always @(posedge clock) begin : check_words
      mix_frame_type e;
      if (!reset && rsp_valid) begin
         n_back <= n_back + 1;
         if (mixer_out_q.size() == 0) begin
            $error("response word with no word outstanding");
            error_count++;
         end else begin
            e = mixer_out_q.pop_front();
            if (rsp_left !== e.left) begin
               $error("left: expected %0d, got %0d", e.left, rsp_left);
               error_count++;
            end
            if (rsp_right !== e.right) begin
               $error("right: expected %0d, got %0d", e.right, rsp_right);
               error_count++;
            end
            if (rsp_granted_voice !== e.voice) begin
               $error("granted_voice: expected %0d, got %0d", e.voice, rsp_granted_voice);
               error_count++;
            end
            if (rsp_active_mask !== e.mask) begin
               $error("active_mask: expected %h, got %h", e.mask, rsp_active_mask);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int pick;
      int first;
      int frames;
      for (int k = 0; k < 2; k++) begin
         for (int s = 0; s < NUM_SOUNDS; s++) begin
            snd_first[k][s]  = '0;
            snd_frames[k][s] = '0;
         end
         for (int v = 0; v < NUM_VOICES; v++) begin
            voice_on[k][v]  = 0;
            voice_snd[k][v] = '0;
            voice_pos[k][v] = '0;
         end
      end
      for (int a = 0; a < 65536; a++) smp_written[a] = 0;

      // Directed: address and value extremes, empty, wrapping and longest sounds
      plan_write(0, 32767);
      plan_write(65535, -32768);
      plan_write(1, -1);
      plan_define(0, 0, 0);
      plan_define(1, 65535, 3);
      plan_define(15, 0, 65536);
      plan_define(2, 0, 1);
      plan_play(0);
      plan_play(1);
      plan_play(15);
      for (int i = 0; i < 5; i++) plan_play(2);
      plan_play(3);                  // all voices busy: refused
      plan(rand_word(OP_TICK));      // low sample first, then clips high
      plan(rand_word(OP_TICK));
      plan_define(15, 100, 1);       // shorten a playing sound
      drain_pending = 1;
      plan(rand_word(OP_TICK));
      plan(rand_word(OP_TICK));
      plan_define(15, 65534, 65535);
      plan_play(15);
      plan(rand_word(OP_TICK));

      // Random mix of all four operations; sample fills count toward the total
      while (n_planned < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 149) == 0) drain_pending = 1;
         if (pick < 12) begin
            plan_write($urandom_range(0, 65535), rand_sample());
         end else if (pick < 27) begin
            first = ($urandom_range(0, 7) == 0) ? 65535 - $urandom_range(0, 8)
                                                : $urandom_range(0, 65535);
            case ($urandom_range(0, 39))
               0: frames = 0;
               1: frames = 65536;
               2: frames = 65535;
               3, 4, 5: frames = $urandom_range(13, 300);
               default: frames = $urandom_range(1, 12);
            endcase
            plan_define($urandom_range(0, 15), first, frames);
         end else if (pick < 52) begin
            plan_play($urandom_range(0, 15));
         end else begin
            plan(rand_word(OP_TICK));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (n_back < n_planned) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mixer_out_q.size() != 0) begin
         $error("%0d response words never arrived", mixer_out_q.size());
         error_count++;
      end
      $display("Ran %0d words: %0d ticks, %0d plays granted, %0d refused.",
               n_taken, tick_count, grant_count, refuse_count);
      $display("Mix sums saturated %0d times; %0d mismatches.", clip_count, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
